FILE: rtl/mme_pkg.sv
// Shared types and constants for the matrix multiply engine.
package mme_pkg;

   localparam int MAX_DIM_DEFAULT      = 64;
   localparam int ELEMENT_BITS_DEFAULT = 16;
   localparam int SIZE_RESET           = 64;
   localparam int ACC_BITS             = 38;
   localparam int INDEX_BITS           = 6;
   localparam int CFG_BITS             = 7;
   localparam int CFG_ADDR_BITS        = 2;

   localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

   typedef enum logic [1:0] {
      KIND_LOAD_A = 2'd0,
      KIND_LOAD_B = 2'd1,
      KIND_QUERY  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [CFG_ADDR_BITS-1:0] {
      REG_ROWS_A       = 2'd0,
      REG_INNER_LENGTH = 2'd1,
      REG_COLS_B       = 2'd2,
      REG_UNUSED       = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

endpackage

FILE: rtl/matrix_multiply_engine_top.sv
// Matrix multiply engine: element stores for A and B and a dot-product sequencer.
// Loads: result in the cycle after start; busy stays low, next word may follow at once.
// Queries: inner_length reads of the two stores, one multiply-accumulate per cycle;
// result goes through store read, product and accumulator registers; busy high until then.
// Out-of-range queries and loads answer in the cycle after start. Receiver cannot stall.
// Sync reset clears control, accumulator, sizes (64, max MAX_DIM); stores hold no reset.
module matrix_multiply_engine_top #(
   parameter int MAX_DIM      = mme_pkg::MAX_DIM_DEFAULT,
   parameter int ELEMENT_BITS = mme_pkg::ELEMENT_BITS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  logic [1:0]                                req_kind,
   input  logic [mme_pkg::INDEX_BITS-1:0]            req_row_index,
   input  logic [mme_pkg::INDEX_BITS-1:0]            req_col_index,
   input  logic signed [ELEMENT_BITS-1:0]            req_element_value,
   output logic                                      rsp_strobe,
   output logic signed [mme_pkg::ACC_BITS-1:0]       rsp_product_value,
   output logic                                      rsp_index_error,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [mme_pkg::CFG_ADDR_BITS-1:0]         csr_index,
   input  logic [mme_pkg::CFG_BITS-1:0]              csr_data
);

   localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int SIZE_W  = $clog2(MAX_DIM + 1);
   localparam int CW      = ((SIZE_W > mme_pkg::CFG_BITS) ? SIZE_W : mme_pkg::CFG_BITS) + 1;
   localparam int PROD_W  = 2 * ELEMENT_BITS;
   localparam int SUM_W   = ((PROD_W > mme_pkg::ACC_BITS) ? PROD_W : mme_pkg::ACC_BITS) + 1;
   localparam int RST_SZ  = (mme_pkg::SIZE_RESET > MAX_DIM) ? MAX_DIM : mme_pkg::SIZE_RESET;

   localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(mme_pkg::ACC_MAX);
   localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(mme_pkg::ACC_MIN);

   // stores
   logic signed [ELEMENT_BITS-1:0] mem_a [DEPTH];
   logic signed [ELEMENT_BITS-1:0] mem_b [DEPTH];

   mme_pkg::state_type state_ff, state_in;

   logic [SIZE_W-1:0] rows_a_ff, inner_ff, cols_b_ff;
   logic [SIZE_W-1:0] cfg_size;

   logic [IDX_W-1:0] row_ff, row_in;
   logic [IDX_W-1:0] col_ff, col_in;
   logic [IDX_W-1:0] k_ff, k_in;

   logic                            v1_ff, last1_ff;
   logic                            v2_ff, last2_ff;
   logic signed [ELEMENT_BITS-1:0]  a_rd_ff, b_rd_ff;
   logic signed [PROD_W-1:0]        prod_ff;
   logic signed [mme_pkg::ACC_BITS-1:0] acc_ff, acc_in;

   logic                                rsp_strobe_ff, rsp_strobe_in;
   logic signed [mme_pkg::ACC_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                                rsp_error_ff, rsp_error_in;

   logic accept;
   logic row_in_a, col_in_k, row_in_k, col_in_b;
   logic load_a_ok, load_b_ok, query_ok, req_error;
   logic rd_en, k_last;
   logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
   logic signed [SUM_W-1:0] sum;

   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // register write with clamp to 1..MAX_DIM
   always_comb begin
      priority if (csr_data == '0) begin
         cfg_size = SIZE_W'(1);
      end else if (CW'(csr_data) > CW'(MAX_DIM)) begin
         cfg_size = SIZE_W'(MAX_DIM);
      end else begin
         cfg_size = SIZE_W'(csr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff <= SIZE_W'(RST_SZ);
         inner_ff  <= SIZE_W'(RST_SZ);
         cols_b_ff <= SIZE_W'(RST_SZ);
      end else if (csr_valid && csr_ready) begin
         unique case (mme_pkg::reg_index_type'(csr_index))
            mme_pkg::REG_ROWS_A:       rows_a_ff <= cfg_size;
            mme_pkg::REG_INNER_LENGTH: inner_ff  <= cfg_size;
            mme_pkg::REG_COLS_B:       cols_b_ff <= cfg_size;
            default: ;
         endcase
      end
   end

   // range checks
   assign row_in_a = CW'(req_row_index) < CW'(rows_a_ff);
   assign col_in_k = CW'(req_col_index) < CW'(inner_ff);
   assign row_in_k = CW'(req_row_index) < CW'(inner_ff);
   assign col_in_b = CW'(req_col_index) < CW'(cols_b_ff);

   assign load_a_ok = row_in_a && col_in_k;
   assign load_b_ok = row_in_k && col_in_b;
   assign query_ok  = row_in_a && col_in_b;

   always_comb begin
      unique case (mme_pkg::kind_type'(req_kind))
         mme_pkg::KIND_LOAD_A: req_error = !load_a_ok;
         mme_pkg::KIND_LOAD_B: req_error = !load_b_ok;
         mme_pkg::KIND_QUERY:  req_error = !query_ok;
         default:              req_error = 1'b0;
      endcase
   end

   assign wr_addr = ADDR_W'(IDX_W'(req_row_index)) * ADDR_W'(MAX_DIM)
                  + ADDR_W'(IDX_W'(req_col_index));

   always_ff @(posedge clock) begin
      if (accept && req_kind == mme_pkg::KIND_LOAD_A && load_a_ok) begin
         mem_a[wr_addr] <= req_element_value;
      end
      if (accept && req_kind == mme_pkg::KIND_LOAD_B && load_b_ok) begin
         mem_b[wr_addr] <= req_element_value;
      end
   end

   // read sequencer
   assign rd_addr_a = ADDR_W'(row_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(k_ff);
   assign rd_addr_b = ADDR_W'(k_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(col_ff);
   assign k_last    = CW'(k_ff) == CW'(inner_ff) - CW'(1);

   always_ff @(posedge clock) begin
      if (rd_en) begin
         a_rd_ff <= mem_a[rd_addr_a];
         b_rd_ff <= mem_b[rd_addr_b];
      end
      prod_ff <= a_rd_ff * b_rd_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mme_pkg::ST_IDLE: begin
            if (accept && req_kind == mme_pkg::KIND_QUERY && query_ok) begin
               state_in = mme_pkg::ST_RUN;
            end
         end
         mme_pkg::ST_RUN: begin
            if (k_last) begin
               state_in = mme_pkg::ST_DRAIN;
            end
         end
         mme_pkg::ST_DRAIN: begin
            if (v2_ff && last2_ff) begin
               state_in = mme_pkg::ST_IDLE;
            end
         end
         default: state_in = mme_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy  = 1'b1;
      rd_en = 1'b0;
      unique case (state_ff)
         mme_pkg::ST_IDLE:  busy  = 1'b0;
         mme_pkg::ST_RUN:   rd_en = 1'b1;
         mme_pkg::ST_DRAIN: ;
         default:           busy  = 1'b1;
      endcase
   end

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      k_in   = k_ff;
      if (accept) begin
         row_in = IDX_W'(req_row_index);
         col_in = IDX_W'(req_col_index);
         k_in   = '0;
      end else if (rd_en) begin
         k_in = k_ff + IDX_W'(1);
      end
   end

   // saturating accumulate
   assign sum = SUM_W'(acc_ff) + SUM_W'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      if (accept && req_kind == mme_pkg::KIND_QUERY) begin
         acc_in = '0;
      end else if (v2_ff) begin
         priority if (sum > SUM_MAX) begin
            acc_in = mme_pkg::ACC_MAX;
         end else if (sum < SUM_MIN) begin
            acc_in = mme_pkg::ACC_MIN;
         end else begin
            acc_in = mme_pkg::ACC_BITS'(sum);
         end
      end
   end

   always_comb begin
      rsp_strobe_in = 1'b0;
      rsp_value_in  = '0;
      rsp_error_in  = 1'b0;
      if (accept && req_kind != mme_pkg::KIND_NONE) begin
         if (req_kind != mme_pkg::KIND_QUERY || req_error) begin
            rsp_strobe_in = 1'b1;
            rsp_error_in  = req_error;
         end
      end else if (v2_ff && last2_ff) begin
         rsp_strobe_in = 1'b1;
         rsp_value_in  = acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mme_pkg::ST_IDLE;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         last1_ff      <= 1'b0;
         last2_ff      <= 1'b0;
         acc_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         v1_ff         <= rd_en;
         v2_ff         <= v1_ff;
         last1_ff      <= rd_en && k_last;
         last2_ff      <= last1_ff;
         acc_ff        <= acc_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      col_ff       <= col_in;
      k_ff         <= k_in;
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_product_value = rsp_value_ff;
   assign rsp_index_error   = rsp_error_ff;

endmodule
